>>> rtl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types and constants for the lru page frame replacer
// frame table geometry, field widths and the update record passed between
// the lookup logic and the frame store
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  // frame table geometry
  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int AGE_W      = SLOT_W;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

  // configuration register
  localparam int              CFG_W     = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;
  localparam int              NUM_W     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // stream field widths
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_SLOT_W  = 3;
  localparam int OUT_PAGE_W  = 16;
  localparam int FAULT_W     = 32;
  localparam int OUT_FIELD_W = 1 + OUT_SLOT_W + 1 + OUT_PAGE_W + FAULT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [AGE_W-1:0]     age_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [FAULT_W-1:0]   fault_t;

  typedef page_t [MAX_FRAMES-1:0] page_vec_t;
  typedef age_t  [MAX_FRAMES-1:0] age_vec_t;

  // outcome of one reference
  typedef struct packed {
    logic  hit;
    logic  evict;
    slot_t slot;
  } upd_t;

endpackage

`default_nettype wire

>>> rtl/lrupr_select.sv
// ----------------------------------------------------------------------------
// lrupr_select: combinational lookup for one page reference
// finds the hit frame, the lowest empty frame or the oldest frame, and
// works out the next age ranks and fault count
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_select (
  input  wire logic [lrupr_pkg::CFG_W-1:0]      frames_in_use,
  input  wire lrupr_pkg::page_vec_t             frame_page,
  input  wire logic [lrupr_pkg::MAX_FRAMES-1:0] frame_valid,
  input  wire lrupr_pkg::age_vec_t              frame_age,
  input  wire lrupr_pkg::fault_t                fault_count,
  input  wire lrupr_pkg::page_t                 page,
  output lrupr_pkg::upd_t                       upd,
  output lrupr_pkg::age_vec_t                   age_nxt,
  output lrupr_pkg::fault_t                     fault_nxt,
  output lrupr_pkg::page_t                      evicted_page
);

  logic [lrupr_pkg::NUM_W-1:0]      n_raw;
  logic [lrupr_pkg::NUM_W-1:0]      n_act;
  logic [lrupr_pkg::MAX_FRAMES-1:0] active;
  logic                             hit_found;
  logic                             empty_found;
  lrupr_pkg::slot_t                 hit_slot;
  lrupr_pkg::slot_t                 empty_slot;
  lrupr_pkg::slot_t                 old_slot;
  lrupr_pkg::slot_t                 slot;
  lrupr_pkg::age_t                  hit_age;
  logic                             bump;

  // clamp frame count to 1..MAX_FRAMES
  always_comb begin
    n_raw = lrupr_pkg::NUM_W'(frames_in_use);
    if (n_raw == '0) begin
      n_act = lrupr_pkg::NUM_W'(1);
    end else if (n_raw > lrupr_pkg::NUM_W'(lrupr_pkg::MAX_FRAMES)) begin
      n_act = lrupr_pkg::NUM_W'(lrupr_pkg::MAX_FRAMES);
    end else begin
      n_act = n_raw;
    end
  end

  // priority searches, lowest index wins
  always_comb begin
    hit_found   = 1'b0;
    empty_found = 1'b0;
    hit_slot    = '0;
    empty_slot  = '0;
    old_slot    = '0;
    for (int i = lrupr_pkg::MAX_FRAMES - 1; i >= 0; i--) begin
      active[i] = lrupr_pkg::NUM_W'(i) < n_act;
      if (active[i] && frame_valid[i] && frame_page[i] == page) begin
        hit_found = 1'b1;
        hit_slot  = lrupr_pkg::SLOT_W'(i);
      end
      if (active[i] && !frame_valid[i]) begin
        empty_found = 1'b1;
        empty_slot  = lrupr_pkg::SLOT_W'(i);
      end
      // ranks of a full set are a permutation of 0..n-1, oldest is n-1
      if (active[i] && frame_valid[i] &&
          lrupr_pkg::NUM_W'(frame_age[i]) == n_act - lrupr_pkg::NUM_W'(1)) begin
        old_slot = lrupr_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (hit_found) begin
      slot = hit_slot;
    end else if (empty_found) begin
      slot = empty_slot;
    end else begin
      slot = old_slot;
    end
    hit_age = frame_age[hit_slot];

    upd.hit   = hit_found;
    upd.evict = !hit_found && !empty_found;
    upd.slot  = slot;

    // on a hit only younger frames age; on a miss every valid frame ages
    for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
      bump = active[i] && frame_valid[i] && (lrupr_pkg::SLOT_W'(i) != slot) &&
             (!hit_found || frame_age[i] < hit_age);
      if (lrupr_pkg::SLOT_W'(i) == slot) begin
        age_nxt[i] = '0;
      end else if (bump) begin
        age_nxt[i] = frame_age[i] + lrupr_pkg::AGE_W'(1);
      end else begin
        age_nxt[i] = frame_age[i];
      end
    end

    if (hit_found || fault_count == '1) begin
      fault_nxt = fault_count;
    end else begin
      fault_nxt = fault_count + lrupr_pkg::FAULT_W'(1);
    end

    evicted_page = upd.evict ? frame_page[old_slot] : '0;
  end

endmodule

`default_nettype wire

>>> rtl/lrupr_frame_store.sv
// ----------------------------------------------------------------------------
// lrupr_frame_store: frame table and fault counter registers
// holds pages, valid bits, age ranks, the frame count setting and the fault
// total; a configuration write empties the table
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_frame_store (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lrupr_pkg::CFG_W-1:0]      cfg_wr_data,
  input  wire logic                             step,
  input  wire lrupr_pkg::page_t                 page,
  input  wire lrupr_pkg::upd_t                  upd,
  input  wire lrupr_pkg::age_vec_t              age_nxt,
  input  wire lrupr_pkg::fault_t                fault_nxt,
  output lrupr_pkg::page_vec_t                  frame_page,
  output logic [lrupr_pkg::MAX_FRAMES-1:0]      frame_valid,
  output lrupr_pkg::age_vec_t                   frame_age,
  output lrupr_pkg::fault_t                     fault_count,
  output logic [lrupr_pkg::CFG_W-1:0]           frames_in_use
);

  logic [lrupr_pkg::CFG_W-1:0]      frames_in_use_r;
  lrupr_pkg::page_vec_t             frame_page_r;
  logic [lrupr_pkg::MAX_FRAMES-1:0] frame_valid_r;
  lrupr_pkg::age_vec_t              frame_age_r;
  lrupr_pkg::fault_t                fault_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= lrupr_pkg::CFG_RESET;
      frame_valid_r   <= '0;
      frame_age_r     <= '0;
      fault_count_r   <= '0;
    end else if (cfg_wr_en) begin
      frames_in_use_r <= cfg_wr_data;
      frame_valid_r   <= '0;
      frame_age_r     <= '0;
      fault_count_r   <= '0;
    end else if (step) begin
      frame_valid_r[upd.slot] <= 1'b1;
      frame_age_r             <= age_nxt;
      fault_count_r           <= fault_nxt;
    end
  end

  // page payload, meaningful only under its valid bit
  always_ff @(posedge clk) begin
    if (step) begin
      frame_page_r[upd.slot] <= page;
    end
  end

  assign frame_page    = frame_page_r;
  assign frame_valid   = frame_valid_r;
  assign frame_age     = frame_age_r;
  assign fault_count   = fault_count_r;
  assign frames_in_use = frames_in_use_r;

  // referenced frame is resident and most recent afterwards
  a_touched_mru: assert property (@(posedge clk) disable iff (!rst_n)
    step && !cfg_wr_en |=> frame_valid_r[$past(upd.slot)] &&
                           frame_age_r[$past(upd.slot)] == '0)
    else $error("referenced frame not most recently used");

  // frames only empty through a configuration write
  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> (frame_valid_r & $past(frame_valid_r)) == $past(frame_valid_r))
    else $error("frame dropped without configuration write");

  // fault total never goes down between configuration writes
  a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr_en |=> fault_count_r >= $past(fault_count_r))
    else $error("fault total decreased");

  // an eviction only happens when every active frame is occupied
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    step && upd.evict |-> frame_valid_r[upd.slot] && !upd.hit)
    else $error("eviction from an empty frame or on a hit");

endmodule

`default_nettype wire

>>> rtl/lru_page_frame_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_page_frame_replacer_core: lru page replacement over a small frame set
// one page reference in, one hit/slot/eviction/fault-total result out
// ----------------------------------------------------------------------------
// The block takes one page reference per transfer and returns one result per
// reference. It sustains one reference per clock while out_tready stays high:
// every frame is compared in parallel and the age ranks are updated in the
// same cycle, so the frame table lookup and update loop sets the rate. A
// reference is held in the input register and then lands in the result
// register, from which the result is offered; the input keeps accepting while
// a result waits on a stalled output, until both registers hold an item.
// Writing cfg_wr_data (frame count, 0 acts as 1, above the table size acts as
// the table size) empties every frame and clears the fault total; write it
// only while no reference is in flight. After reset the frame count is 3 and
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_frame_replacer_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // page reference stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [lrupr_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] page_number
  // result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [0] hit, [3:1] frame_slot, [4] evicted_valid, [20:5] evicted_page,
  // [52:21] fault_total, [55:53] zero
  output logic [lrupr_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // frame count register
  input  wire logic                               cfg_wr_en,
  input  wire logic [lrupr_pkg::CFG_W-1:0]        cfg_wr_data
);

  // input register
  logic                 in_valid_r;
  lrupr_pkg::page_t     in_page_r;

  // result register
  logic                                out_valid_r;
  logic                                out_hit_r;
  logic [lrupr_pkg::OUT_SLOT_W-1:0]    out_slot_r;
  logic                                out_evict_r;
  logic [lrupr_pkg::OUT_PAGE_W-1:0]    out_page_r;
  lrupr_pkg::fault_t                   out_fault_r;

  // frame table view and lookup outcome
  lrupr_pkg::page_vec_t             frame_page;
  logic [lrupr_pkg::MAX_FRAMES-1:0] frame_valid;
  lrupr_pkg::age_vec_t              frame_age;
  lrupr_pkg::fault_t                fault_count;
  logic [lrupr_pkg::CFG_W-1:0]      frames_in_use;
  lrupr_pkg::upd_t                  upd;
  lrupr_pkg::age_vec_t              age_nxt;
  lrupr_pkg::fault_t                fault_nxt;
  lrupr_pkg::page_t                 evicted_page;

  logic advance;

  // the held reference moves on when the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_page_r <= lrupr_pkg::PAGE_BITS'(in_tdata);
    end
  end

  lrupr_select u_select (
    .frames_in_use (frames_in_use),
    .frame_page    (frame_page),
    .frame_valid   (frame_valid),
    .frame_age     (frame_age),
    .fault_count   (fault_count),
    .page          (in_page_r),
    .upd           (upd),
    .age_nxt       (age_nxt),
    .fault_nxt     (fault_nxt),
    .evicted_page  (evicted_page)
  );

  // table state commits in the same edge the result is captured, so the
  // next reference already sees it
  lrupr_frame_store u_frame_store (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .step          (advance),
    .page          (in_page_r),
    .upd           (upd),
    .age_nxt       (age_nxt),
    .fault_nxt     (fault_nxt),
    .frame_page    (frame_page),
    .frame_valid   (frame_valid),
    .frame_age     (frame_age),
    .fault_count   (fault_count),
    .frames_in_use (frames_in_use)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit_r   <= upd.hit;
      out_slot_r  <= lrupr_pkg::OUT_SLOT_W'(upd.slot);
      out_evict_r <= upd.evict;
      out_page_r  <= lrupr_pkg::OUT_PAGE_W'(evicted_page);
      out_fault_r <= fault_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{lrupr_pkg::OUT_PAD_W{1'b0}}, out_fault_r, out_page_r,
                       out_evict_r, out_slot_r, out_hit_r};

  // a result never reports both a hit and an eviction
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evict_r))
    else $error("result shows hit and eviction together");

  // the input side is open whenever the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lru_page_frame_replacer_core
// page references stream in, and every hit/slot/eviction/fault-total result
// is checked against a cycle-free lru frame table model kept in the bench.
// the frame count is rewritten between phases over its whole 4-bit range,
// both stream sides idle in short random bursts, and the run ends quiet
// ----------------------------------------------------------------------------

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_REFS  = 1650;
  localparam int QUIET_TAIL   = 150;   // pending entries left when idling stops
  localparam int SETTLE       = 2;     // idle cycles before a frame count write
  localparam int DRAIN_CYCLES = 20;

  // what one pending stimulus entry asks of the feeder
  typedef enum logic [1:0] {
    ACT_REF,    // page reference transfer
    ACT_CFG,    // frame count write once the block is idle
    ACT_DRAIN   // hold off until every result is back
  } act_e;

  typedef struct {
    act_e             act;
    lrupr_pkg::page_t val;
  } pend_t;

  // one expected result, field for field
  typedef struct packed {
    logic              hit;
    lrupr_pkg::slot_t  slot;
    logic              ev_valid;
    lrupr_pkg::page_t  ev_page;
    lrupr_pkg::fault_t faults;
  } res_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [lrupr_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [lrupr_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                              cfg_wr_en = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]       cfg_wr_data = '0;

  lru_page_frame_replacer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // frame table model
  // --------------------------------------------------------------------------
  logic [lrupr_pkg::CFG_W-1:0] frame_cnt_reg = lrupr_pkg::CFG_RESET;
  lrupr_pkg::page_t            frm_page [lrupr_pkg::MAX_FRAMES];
  logic                        frm_used [lrupr_pkg::MAX_FRAMES];
  lrupr_pkg::age_t             frm_rank [lrupr_pkg::MAX_FRAMES];
  lrupr_pkg::fault_t           fault_sum;

  pend_t pend_q [$];   // stimulus not yet handed to the block
  res_t  result_q [$]; // results owed by the block, oldest first
  int    err_cnt = 0;

  // empties every frame and zeroes the fault total
  function automatic void clear_frames();
    for (int i = 0; i < lrupr_pkg::MAX_FRAMES; i++) begin
      frm_page[i] = '0;
      frm_used[i] = 1'b0;
      frm_rank[i] = '0;
    end
    fault_sum = '0;
  endfunction

  // frame count as the block sees it: zero acts as one, oversize is clamped
  function automatic int live_frames();
    int n;
    n = int'(frame_cnt_reg);
    if (n < 1) n = 1;
    if (n > lrupr_pkg::MAX_FRAMES) n = lrupr_pkg::MAX_FRAMES;
    return n;
  endfunction

  // frame f becomes most recently used; valid frames younger than lim age
  // by one, or every other valid frame when every is set
  function automatic void promote(int n, int f, logic every, lrupr_pkg::age_t lim);
    for (int i = 0; i < n; i++) begin
      if (i != f && frm_used[i] && (every || frm_rank[i] < lim)) frm_rank[i]++;
    end
    frm_rank[f] = '0;
    frm_used[f] = 1'b1;
  endfunction

  // applies one page reference to the table and returns its result
  function automatic res_t resolve_reference(lrupr_pkg::page_t pg);
    res_t r;
    int   n;
    int   s;
    logic found;
    n     = live_frames();
    r     = '0;
    s     = 0;
    found = 1'b0;
    // lowest matching frame wins
    for (int i = 0; i < n; i++) begin
      if (!r.hit && frm_used[i] && frm_page[i] == pg) begin
        r.hit = 1'b1;
        s     = i;
      end
    end
    if (r.hit) begin
      promote(n, s, 1'b0, frm_rank[s]);
    end else begin
      if (fault_sum != '1) fault_sum++;
      // lowest empty frame first
      for (int i = 0; i < n; i++) begin
        if (!found && !frm_used[i]) begin
          found = 1'b1;
          s     = i;
        end
      end
      // table full: oldest rank goes, lowest index on a tie
      if (!found) begin
        s = 0;
        for (int i = 1; i < n; i++) begin
          if (frm_rank[i] > frm_rank[s]) s = i;
        end
        r.ev_valid = 1'b1;
        r.ev_page  = frm_page[s];
      end
      promote(n, s, 1'b1, '0);
      frm_page[s] = pg;
    end
    r.slot   = lrupr_pkg::slot_t'(s);
    r.faults = fault_sum;
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic logic in_tail();
    return pend_q.size() < QUIET_TAIL;
  endfunction

  initial clear_frames();

  // --------------------------------------------------------------------------
  // monitor: everything sampled at the rising edge
  // --------------------------------------------------------------------------
  logic in_took = 1'b0;   // input transfer at the last rising edge

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      in_took = 1'b0;
    end else begin
      // result side first, so a fresh reference never pairs with its own edge
      if (out_tvalid && out_tready) begin
        got.hit      = out_tdata[0];
        got.slot     = out_tdata[3:1];
        got.ev_valid = out_tdata[4];
        got.ev_page  = out_tdata[20:5];
        got.faults   = out_tdata[52:21];
        if (result_q.size() == 0) begin
          $error("result transfer with no reference outstanding");
          err_cnt++;
        end else begin
          want = result_q.pop_front();
          cmp_field("hit", 32'(want.hit), 32'(got.hit));
          cmp_field("frame_slot", 32'(want.slot), 32'(got.slot));
          cmp_field("evicted_valid", 32'(want.ev_valid), 32'(got.ev_valid));
          cmp_field("evicted_page", 32'(want.ev_page), 32'(got.ev_page));
          cmp_field("fault_total", want.faults, got.faults);
        end
      end
      if (in_tvalid && in_tready) result_q.push_back(resolve_reference(in_tdata));
      in_took = in_tvalid && in_tready;
      // writes only happen with the block idle, so the model clears at once
      if (cfg_wr_en) begin
        frame_cnt_reg = cfg_wr_data;
        clear_frames();
      end
    end
  end

  // --------------------------------------------------------------------------
  // feeder: drives references and frame count writes at the falling edge
  // --------------------------------------------------------------------------
  int hold_cnt = 0;
  int idle_run = 0;

  always @(negedge clk) begin
    logic                        nv;
    lrupr_pkg::page_t            nd;
    logic                        ce;
    logic [lrupr_pkg::CFG_W-1:0] cd;
    pend_t                       head;
    nv = 1'b0;
    nd = in_tdata;
    ce = 1'b0;
    cd = cfg_wr_data;
    if (rst_n) begin
      // nothing presented and nothing owed: the block has gone quiet
      if (result_q.size() == 0 && !in_tvalid) idle_run++;
      else idle_run = 0;
      if (in_tvalid && !in_took) begin
        nv = 1'b1;   // still waiting for the transfer
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (pend_q.size() != 0) begin
        head = pend_q[0];
        case (head.act)
          ACT_REF: begin
            if (!in_tail() && $urandom_range(0, 3) == 0) begin
              hold_cnt = $urandom_range(0, 2);
            end else begin
              nv = 1'b1;
              nd = head.val;
              void'(pend_q.pop_front());
            end
          end
          ACT_CFG: begin
            if (idle_run >= SETTLE) begin
              ce = 1'b1;
              cd = head.val[lrupr_pkg::CFG_W-1:0];
              void'(pend_q.pop_front());
              idle_run = 0;
            end
          end
          ACT_DRAIN: begin
            if (idle_run >= 1) void'(pend_q.pop_front());
          end
          default: void'(pend_q.pop_front());
        endcase
      end
    end
    in_tvalid   <= nv;
    in_tdata    <= nd;
    cfg_wr_en   <= ce;
    cfg_wr_data <= cd;
  end

  // result side back-pressure in short bursts, none near the end
  int stall_cnt = 0;

  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt--;
      rdy = 1'b0;
    end else if (!in_tail() && $urandom_range(0, 3) == 0) begin
      stall_cnt = $urandom_range(0, 2);
      rdy = 1'b0;
    end
    out_tready <= rdy;
  end

  // run limit
  int cyc_cnt = 0;

  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic void push_act(act_e a, lrupr_pkg::page_t v);
    pend_t p;
    p.act = a;
    p.val = v;
    pend_q.push_back(p);
  endfunction

  function automatic lrupr_pkg::page_t any_page();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return lrupr_pkg::page_t'($urandom);
    endcase
  endfunction

  function automatic void build_directed();
    // reset frame count of three: fill, hit, then two evictions and a refault
    push_act(ACT_REF, 16'h0000);
    push_act(ACT_REF, 16'hFFFF);
    push_act(ACT_REF, 16'h1234);
    push_act(ACT_REF, 16'h0000);
    push_act(ACT_REF, 16'h5555);
    push_act(ACT_REF, 16'hAAAA);
    push_act(ACT_REF, 16'hFFFF);
    push_act(ACT_DRAIN, '0);
    // zero frame count acts as a single frame
    push_act(ACT_CFG, 16'd0);
    push_act(ACT_REF, 16'h0007);
    push_act(ACT_REF, 16'h0007);
    push_act(ACT_REF, 16'h0008);
    push_act(ACT_REF, 16'h0007);
    // oversize count clamps to the full table: fill all, evict, then hit
    push_act(ACT_CFG, 16'd15);
    for (int i = 1; i <= 9; i++) push_act(ACT_REF, lrupr_pkg::page_t'(i));
    push_act(ACT_REF, 16'h0002);
    // back-to-back writes, then one frame with the top page bit
    push_act(ACT_CFG, 16'd8);
    push_act(ACT_CFG, 16'd1);
    push_act(ACT_REF, 16'h8000);
    push_act(ACT_CFG, 16'd9);
  endfunction

  // phases of references over a small working set that drifts, with noise
  function automatic void build_random();
    int                          made;
    int                          len;
    int                          eff;
    lrupr_pkg::page_t            pool [$];
    logic [lrupr_pkg::CFG_W-1:0] cnt;
    made = 0;
    while (made < RANDOM_REFS) begin
      case ($urandom_range(0, 9))
        0: cnt = 4'd0;
        1: cnt = 4'd1;
        2: cnt = 4'd8;
        3: cnt = 4'd15;
        default: cnt = lrupr_pkg::CFG_W'($urandom_range(0, 15));
      endcase
      push_act(ACT_CFG, lrupr_pkg::page_t'(cnt));
      eff = (cnt < 1) ? 1 : (cnt > lrupr_pkg::MAX_FRAMES) ? lrupr_pkg::MAX_FRAMES :
            int'(cnt);
      pool.delete();
      for (int i = 0; i < eff + $urandom_range(0, 3); i++) pool.push_back(any_page());
      len = $urandom_range(40, 160);
      if (len > RANDOM_REFS - made) len = RANDOM_REFS - made;
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: push_act(ACT_REF, lrupr_pkg::page_t'($urandom));
          1: begin
            // working set drifts by one page
            pool[$urandom_range(0, pool.size() - 1)] = any_page();
            push_act(ACT_REF, pool[$urandom_range(0, pool.size() - 1)]);
          end
          default: push_act(ACT_REF, pool[$urandom_range(0, pool.size() - 1)]);
        endcase
        if ($urandom_range(0, 199) == 0) push_act(ACT_DRAIN, '0);
      end
      made += len;
    end
  endfunction

  initial begin
    build_directed();
    build_random();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // wait for the feeder to run dry and every result to come back
    while (pend_q.size() != 0 || in_tvalid || result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (result_q.size() != 0) begin
      $error("%0d references never produced a result", result_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
